// ===== sv/cle_pkg.sv =====
// shared types, codes and constants of the console line editor
`default_nettype none
package cle_pkg;

  localparam int FIELD_W = 6;
  localparam int KEY_W = 8;
  localparam int LINE_CAPACITY_DEF = 64;
  localparam int HISTORY_DEPTH_DEF = 8;

  localparam logic [KEY_W-1:0] KEY_ENTER = 8'd10;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [KEY_W-1:0] PRINT_LO = 8'd32;
  localparam logic [KEY_W-1:0] PRINT_HI = 8'd126;

  localparam logic [KEY_W-1:0] KEY_UP_RESET = 8'd128;
  localparam logic [KEY_W-1:0] KEY_DOWN_RESET = 8'd129;
  localparam logic [KEY_W-1:0] KEY_LEFT_RESET = 8'd130;
  localparam logic [KEY_W-1:0] KEY_RIGHT_RESET = 8'd131;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_RIGHT = 2'd3;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_LEFT = 3'd1,
    ACT_RIGHT = 3'd2,
    ACT_REDRAW = 3'd3,
    ACT_COMMIT = 3'd4,
    ACT_CLEAR = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_CURM1, IDX_LEN, IDX_INC, IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {RD_IDX, RD_NEXT, RD_PREV} rd_sel_t;

  typedef enum logic [1:0] {WD_LINE, WD_HIST, WD_KEY} wd_sel_t;

  typedef enum logic [2:0] {
    RO_NONE, RO_LEFT, RO_RIGHT, RO_BS, RO_INS, RO_LOAD, RO_CLEAR
  } reg_op_t;

  typedef enum logic [1:0] {BR_NONE, BR_UP, BR_DOWN} br_op_t;

  typedef enum logic {HS_NEWEST, HS_BROWSE} hist_sel_t;

  typedef struct packed {
    logic take_key;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    logic line_wr;
    wd_sel_t wd_sel;
    logic hist_wr;
    hist_sel_t hist_sel;
    reg_op_t reg_op;
    br_op_t br_op;
    logic commit;
    logic emit;
    action_t out_act;
    logic out_stream;
    logic out_last;
    logic out_zero_pos;
  } cmd_t;

  typedef struct packed {
    logic k_updown;
    logic k_up;
    logic k_left;
    logic k_right;
    logic k_enter;
    logic k_bs;
    logic k_print;
    logic hist_empty;
    logic browsing;
    logic down_exit;
    logic cur_zero;
    logic cur_at_end;
    logic len_zero;
    logic line_full;
    logic bs_more;
    logic ins_more;
    logic ld_more;
    logic idx_last;
    logic newest_eq;
    logic char_diff;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/cle_datapath.sv =====
// line and history memories, editor registers and result register
`default_nettype none
module cle_datapath #(
  parameter int LINE_CAPACITY = 64,
  parameter int HISTORY_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cle_pkg::cmd_t cmd,
  output cle_pkg::status_t status,
  input  wire logic [cle_pkg::KEY_W-1:0] key_code,
  input  wire logic cfg_write,
  input  wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cle_pkg::KEY_W-1:0] cfg_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] action,
  output logic [cle_pkg::KEY_W-1:0] char_out,
  output logic [cle_pkg::FIELD_W-1:0] char_index,
  output logic [cle_pkg::FIELD_W-1:0] cursor_pos,
  output logic [cle_pkg::FIELD_W-1:0] line_length,
  output logic last
);
  import cle_pkg::*;

  localparam int LW = $clog2(LINE_CAPACITY);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int UW = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_ENTRIES = HISTORY_DEPTH << LW;

  logic [KEY_W-1:0] up_code, down_code, left_code, right_code, key;
  logic [KEY_W-1:0] line_mem [LINE_CAPACITY];
  logic [KEY_W-1:0] hist_mem [HIST_ENTRIES];
  logic [LW-1:0] hist_len [HISTORY_DEPTH];
  logic [KEY_W-1:0] line_rdata, hist_rdata, line_wdata;
  logic [LW-1:0] len, cursor, idx, line_raddr;
  logic [HW-1:0] head, oldest, bidx, newest, head_inc, oldest_inc, slot, hslot;
  logic [HW:0] slot_sum;
  logic [UW-1:0] used;
  logic browsing;
  logic [LW-1:0] ld_n;

  assign newest = (head == '0) ? HW'(HISTORY_DEPTH - 1) : HW'(head - 1'b1);
  assign head_inc = (head == HW'(HISTORY_DEPTH - 1)) ? '0 : HW'(head + 1'b1);
  assign oldest_inc = (oldest == HW'(HISTORY_DEPTH - 1)) ? '0 : HW'(oldest + 1'b1);
  assign slot_sum = {1'b0, oldest} + {1'b0, bidx};
  assign slot = (slot_sum >= (HW+1)'(HISTORY_DEPTH)) ?
                HW'(slot_sum - (HW+1)'(HISTORY_DEPTH)) : HW'(slot_sum);
  assign hslot = (cmd.hist_sel == HS_BROWSE) ? slot : newest;
  assign ld_n = hist_len[slot];

  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT: line_raddr = LW'(idx + 1'b1);
      RD_PREV: line_raddr = LW'(idx - 1'b1);
      default: line_raddr = idx;
    endcase
    case (cmd.wd_sel)
      WD_HIST: line_wdata = hist_rdata;
      WD_KEY:  line_wdata = key;
      default: line_wdata = line_rdata;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.line_wr) begin
      line_mem[idx] <= line_wdata;
    end
    line_rdata <= line_mem[line_raddr];
    if (cmd.hist_wr) begin
      hist_mem[{head, idx}] <= line_rdata;
    end
    hist_rdata <= hist_mem[{hslot, idx}];
    if (cmd.commit) begin
      hist_len[head] <= len;
    end
    if (cmd.take_key) begin
      key <= key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_code <= KEY_UP_RESET;
      down_code <= KEY_DOWN_RESET;
      left_code <= KEY_LEFT_RESET;
      right_code <= KEY_RIGHT_RESET;
      len <= '0;
      cursor <= '0;
      idx <= '0;
      head <= '0;
      oldest <= '0;
      used <= '0;
      bidx <= '0;
      browsing <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_UP:    up_code <= cfg_data;
          REG_KEY_DOWN:  down_code <= cfg_data;
          REG_KEY_LEFT:  left_code <= cfg_data;
          REG_KEY_RIGHT: right_code <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.idx_op)
        IDX_ZERO:  idx <= '0;
        IDX_CURM1: idx <= LW'(cursor - 1'b1);
        IDX_LEN:   idx <= len;
        IDX_INC:   idx <= LW'(idx + 1'b1);
        IDX_DEC:   idx <= LW'(idx - 1'b1);
        default: ;
      endcase
      case (cmd.reg_op)
        RO_LEFT:  cursor <= LW'(cursor - 1'b1);
        RO_RIGHT: cursor <= LW'(cursor + 1'b1);
        RO_BS: begin
          cursor <= LW'(cursor - 1'b1);
          len <= LW'(len - 1'b1);
        end
        RO_INS: begin
          cursor <= LW'(cursor + 1'b1);
          len <= LW'(len + 1'b1);
        end
        RO_LOAD: begin
          cursor <= ld_n;
          len <= ld_n;
        end
        RO_CLEAR: begin
          cursor <= '0;
          len <= '0;
          browsing <= 1'b0;
          bidx <= '0;
        end
        default: ;
      endcase
      case (cmd.br_op)
        BR_UP: begin
          if (!browsing) begin
            browsing <= 1'b1;
            bidx <= HW'(used - 1'b1);
          end else if (bidx != '0) begin
            bidx <= HW'(bidx - 1'b1);
          end
        end
        BR_DOWN: bidx <= HW'(bidx + 1'b1);
        default: ;
      endcase
      if (cmd.commit) begin
        head <= head_inc;
        if (used == UW'(HISTORY_DEPTH)) begin
          oldest <= oldest_inc;
        end else begin
          used <= UW'(used + 1'b1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      action <= cmd.out_act;
      char_out <= cmd.out_stream ? line_rdata : '0;
      char_index <= cmd.out_stream ? FIELD_W'(idx) : '0;
      cursor_pos <= cmd.out_zero_pos ? '0 : FIELD_W'(cursor);
      line_length <= cmd.out_zero_pos ? '0 : FIELD_W'(len);
      last <= cmd.out_last;
    end
  end

  always_comb begin
    status.k_updown = (key == up_code) || (key == down_code);
    status.k_up = (key == up_code);
    status.k_left = (key == left_code);
    status.k_right = (key == right_code);
    status.k_enter = (key == KEY_ENTER);
    status.k_bs = (key == KEY_BACKSPACE);
    status.k_print = (key >= PRINT_LO) && (key <= PRINT_HI);
    status.hist_empty = (used == '0);
    status.browsing = browsing;
    status.down_exit = ({1'b0, bidx} + 1'b1) >= (HW+1)'(used);
    status.cur_zero = (cursor == '0);
    status.cur_at_end = (cursor >= len);
    status.len_zero = (len == '0);
    status.line_full = ({1'b0, len} >= (LW+1)'(LINE_CAPACITY - 1));
    status.bs_more = ({1'b0, idx} + 1'b1) < {1'b0, len};
    status.ins_more = (idx > cursor);
    status.ld_more = (idx < ld_n);
    status.idx_last = ({1'b0, idx} + 1'b1) == {1'b0, len};
    status.newest_eq = (hist_len[newest] == len);
    status.char_diff = (line_rdata != hist_rdata);
    status.out_free = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

// ===== sv/cle_controller.sv =====
// sequencer for key decode, line edits, history browse and commit
`default_nettype none
module cle_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire cle_pkg::status_t status,
  output cle_pkg::cmd_t cmd
);
  import cle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_BS_RD, S_BS_WR, S_INS_RD, S_INS_WR, S_LD_RD, S_LD_WR,
    S_ST_RD, S_ST_OUT, S_SGL, S_ST_CHK, S_CMP_RD, S_CMP_CHK, S_CP_RD, S_CP_WR,
    S_FIN
  } state_t;

  state_t state, state_next;
  action_t act, act_next;
  logic is_enter, is_enter_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    act_next = act;
    is_enter_next = is_enter;
    cmd.out_zero_pos = is_enter;
    cmd.out_act = act;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_key = 1'b1;
          is_enter_next = 1'b0;
          act_next = ACT_NONE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_SGL;
        act_next = ACT_NONE;
        if (status.k_updown) begin
          if (status.hist_empty) begin
            act_next = ACT_NONE;
          end else if (status.k_up) begin
            cmd.br_op = BR_UP;
            cmd.idx_op = IDX_ZERO;
            act_next = ACT_REDRAW;
            state_next = S_LD_RD;
          end else if (!status.browsing) begin
            act_next = ACT_NONE;
          end else if (status.down_exit) begin
            cmd.reg_op = RO_CLEAR;
            act_next = ACT_CLEAR;
          end else begin
            cmd.br_op = BR_DOWN;
            cmd.idx_op = IDX_ZERO;
            act_next = ACT_REDRAW;
            state_next = S_LD_RD;
          end
        end else if (status.k_left) begin
          if (!status.cur_zero) begin
            cmd.reg_op = RO_LEFT;
            act_next = ACT_LEFT;
          end
        end else if (status.k_right) begin
          if (!status.cur_at_end) begin
            cmd.reg_op = RO_RIGHT;
            act_next = ACT_RIGHT;
          end
        end else if (status.k_enter) begin
          is_enter_next = 1'b1;
          act_next = ACT_COMMIT;
          cmd.idx_op = IDX_ZERO;
          state_next = S_ST_RD;
        end else if (status.k_bs) begin
          if (!status.cur_zero && !status.len_zero) begin
            act_next = ACT_REDRAW;
            cmd.idx_op = IDX_CURM1;
            state_next = S_BS_RD;
          end
        end else if (status.k_print) begin
          if (!status.line_full) begin
            act_next = ACT_REDRAW;
            cmd.idx_op = IDX_LEN;
            state_next = S_INS_RD;
          end
        end
      end
      S_BS_RD: begin
        cmd.rd_sel = RD_NEXT;
        if (status.bs_more) begin
          state_next = S_BS_WR;
        end else begin
          cmd.reg_op = RO_BS;
          cmd.idx_op = IDX_ZERO;
          state_next = S_ST_RD;
        end
      end
      S_BS_WR: begin
        cmd.line_wr = 1'b1;
        cmd.wd_sel = WD_LINE;
        cmd.idx_op = IDX_INC;
        state_next = S_BS_RD;
      end
      S_INS_RD: begin
        cmd.rd_sel = RD_PREV;
        if (status.ins_more) begin
          state_next = S_INS_WR;
        end else begin
          cmd.line_wr = 1'b1;
          cmd.wd_sel = WD_KEY;
          cmd.reg_op = RO_INS;
          cmd.idx_op = IDX_ZERO;
          state_next = S_ST_RD;
        end
      end
      S_INS_WR: begin
        cmd.line_wr = 1'b1;
        cmd.wd_sel = WD_LINE;
        cmd.idx_op = IDX_DEC;
        state_next = S_INS_RD;
      end
      S_LD_RD: begin
        cmd.hist_sel = HS_BROWSE;
        if (status.ld_more) begin
          state_next = S_LD_WR;
        end else begin
          cmd.reg_op = RO_LOAD;
          cmd.idx_op = IDX_ZERO;
          state_next = S_ST_RD;
        end
      end
      S_LD_WR: begin
        cmd.hist_sel = HS_BROWSE;
        cmd.line_wr = 1'b1;
        cmd.wd_sel = WD_HIST;
        cmd.idx_op = IDX_INC;
        state_next = S_LD_RD;
      end
      S_ST_RD: begin
        state_next = status.len_zero ? S_SGL : S_ST_OUT;
      end
      S_ST_OUT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.out_stream = 1'b1;
          cmd.out_last = status.idx_last;
          if (status.idx_last) begin
            state_next = is_enter ? S_ST_CHK : S_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_next = S_ST_RD;
          end
        end
      end
      S_SGL: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.out_last = 1'b1;
          state_next = is_enter ? S_ST_CHK : S_IDLE;
        end
      end
      S_ST_CHK: begin
        cmd.idx_op = IDX_ZERO;
        if (status.len_zero) begin
          state_next = S_FIN;
        end else if (!status.hist_empty && status.newest_eq) begin
          state_next = S_CMP_RD;
        end else begin
          state_next = S_CP_RD;
        end
      end
      S_CMP_RD: begin
        cmd.hist_sel = HS_NEWEST;
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        cmd.hist_sel = HS_NEWEST;
        if (status.char_diff) begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_CP_RD;
        end else if (status.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_CMP_RD;
        end
      end
      S_CP_RD: begin
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.hist_wr = 1'b1;
        if (status.idx_last) begin
          cmd.commit = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_CP_RD;
        end
      end
      S_FIN: begin
        cmd.reg_op = RO_CLEAR;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act <= ACT_NONE;
      is_enter <= 1'b0;
    end else begin
      state <= state_next;
      act <= act_next;
      is_enter <= is_enter_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/console_line_editor_with_history.sv =====
// top level of the console line editor with history ring
//
//   channel  signals                            direction
//   input    in_valid in_stall key_code         key in
//   output   out_valid out_stall action ...     result out
//   config   cfg_write cfg_index cfg_data       write only
//
// one key at a time; cursor keys and dead keys pass decode and then give a single result
// edits and browse take a read and a write state per moved character, and a read and
// an output state per streamed one; enter does likewise for stream, compare and copy
// these per-character states come from the single read port of the line memory, registered read
// reset is synchronous and empties the line and the history ring, no clearing pass
// a stalled result holds the sequencer; the next key is taken with it still waiting
`default_nettype none
module console_line_editor_with_history #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF,
  parameter int HISTORY_DEPTH = cle_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [cle_pkg::KEY_W-1:0] key_code,
  input  wire logic cfg_write,
  input  wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cle_pkg::KEY_W-1:0] cfg_data,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] action,
  output logic [cle_pkg::KEY_W-1:0] char_out,
  output logic [cle_pkg::FIELD_W-1:0] char_index,
  output logic [cle_pkg::FIELD_W-1:0] cursor_pos,
  output logic [cle_pkg::FIELD_W-1:0] line_length,
  output logic last
);
  import cle_pkg::*;

  cmd_t cmd;
  status_t status;

  cle_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd)
  );

  cle_datapath #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .key_code(key_code),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .char_out(char_out),
    .char_index(char_index),
    .cursor_pos(cursor_pos),
    .line_length(line_length),
    .last(last)
  );

endmodule
`default_nettype wire

// ===== sv/cle_checker.sv =====
// port checker for the console line editor and its bind
`default_nettype none
module cle_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [2:0] action,
  input wire logic [cle_pkg::FIELD_W-1:0] cursor_pos,
  input wire logic [cle_pkg::FIELD_W-1:0] line_length,
  input wire logic last
);
  import cle_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_key: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second key taken while first in work");

  a_stream_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("key taken in the middle of a line stream");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action != ACT_REDRAW) && (action != ACT_COMMIT) |-> last)
    else $error("non-streaming result without last");

  a_commit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_COMMIT) |-> (cursor_pos == '0) && (line_length == '0))
    else $error("commit transfer reports nonzero cursor or length");

endmodule

bind console_line_editor_with_history cle_checker u_cle_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .action(action),
  .cursor_pos(cursor_pos),
  .line_length(line_length),
  .last(last)
);
`default_nettype wire

// ===== dv/tb_console_line_editor_with_history.sv =====
// testbench for the console line editor: random and directed keys checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_console_line_editor_with_history;
  import cle_pkg::*;

  localparam int LINE_CAP = 64;
  localparam int HIST_DEPTH = 8;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] ch;
    logic [5:0] idx;
    logic [5:0] cur;
    logic [5:0] len;
    logic fin;
  } editor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] key_code = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] action;
  logic [7:0] char_out;
  logic [5:0] char_index;
  logic [5:0] cursor_pos;
  logic [5:0] line_length;
  logic last;

  console_line_editor_with_history uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .key_code(key_code),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .action(action), .char_out(char_out),
    .char_index(char_index), .cursor_pos(cursor_pos), .line_length(line_length),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0] up_key, down_key, left_key, right_key;
  logic [7:0] line_buf [LINE_CAP];
  int line_n, cursor_at;
  logic [7:0] hist_buf [HIST_DEPTH][LINE_CAP];
  int hist_len [HIST_DEPTH];
  int hist_used, hist_head, browse_at;
  bit browsing_on;

  logic [7:0] pending_keys [$];
  editor_result_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int hold_count = 0;
  int idle_cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("error at %0t: %s", $realtime, what);
  endtask

  task automatic push_result(input action_t a, input int c, input int i, input int cu,
                             input int ln, input bit f);
    editor_result_t r;
    r.act = a; r.ch = c[7:0]; r.idx = i[5:0]; r.cur = cu[5:0]; r.len = ln[5:0]; r.fin = f;
    expected_results.push_back(r);
  endtask

  task automatic stream_line(input action_t a, input int cu, input int ln);
    if (line_n == 0) begin
      push_result(a, 0, 0, cu, ln, 1'b1);
    end else begin
      for (int i = 0; i < line_n; i++) push_result(a, line_buf[i], i, cu, ln, i == line_n - 1);
    end
  endtask

  task automatic clear_line();
    for (int i = 0; i < LINE_CAP; i++) line_buf[i] = '0;
    line_n = 0;
    cursor_at = 0;
  endtask

  task automatic predict_key(input logic [7:0] c);
    int s;
    bit same;
    if (c == up_key || c == down_key) begin
      if (hist_used == 0) begin
        push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
        return;
      end
      if (c == up_key) begin
        if (!browsing_on) begin
          browsing_on = 1'b1;
          browse_at = hist_used - 1;
        end else if (browse_at > 0) begin
          browse_at--;
        end
      end else begin
        if (!browsing_on) begin
          push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
          return;
        end
        browse_at++;
        if (browse_at >= hist_used) begin
          browsing_on = 1'b0;
          browse_at = 0;
          clear_line();
          push_result(ACT_CLEAR, 0, 0, 0, 0, 1'b1);
          return;
        end
      end
      s = (hist_head + HIST_DEPTH - hist_used + browse_at) % HIST_DEPTH;
      clear_line();
      for (int i = 0; i < hist_len[s]; i++) line_buf[i] = hist_buf[s][i];
      line_n = hist_len[s];
      cursor_at = line_n;
      stream_line(ACT_REDRAW, cursor_at, line_n);
    end else if (c == left_key) begin
      if (cursor_at == 0) begin
        push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
      end else begin
        cursor_at--;
        push_result(ACT_LEFT, 0, 0, cursor_at, line_n, 1'b1);
      end
    end else if (c == right_key) begin
      if (cursor_at >= line_n) begin
        push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
      end else begin
        cursor_at++;
        push_result(ACT_RIGHT, 0, 0, cursor_at, line_n, 1'b1);
      end
    end else if (c == KEY_ENTER) begin
      stream_line(ACT_COMMIT, 0, 0);
      if (line_n != 0) begin
        same = 1'b0;
        if (hist_used > 0) begin
          s = (hist_head + HIST_DEPTH - 1) % HIST_DEPTH;
          same = hist_len[s] == line_n;
          for (int i = 0; i < line_n; i++) if (hist_buf[s][i] != line_buf[i]) same = 1'b0;
        end
        if (!same) begin
          for (int i = 0; i < LINE_CAP; i++) hist_buf[hist_head][i] = line_buf[i];
          hist_len[hist_head] = line_n;
          hist_head = (hist_head + 1) % HIST_DEPTH;
          if (hist_used < HIST_DEPTH) hist_used++;
        end
      end
      clear_line();
      browsing_on = 1'b0;
      browse_at = 0;
    end else if (c == KEY_BACKSPACE) begin
      if (cursor_at == 0 || line_n == 0) begin
        push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
      end else begin
        for (int i = cursor_at - 1; i + 1 < line_n; i++) line_buf[i] = line_buf[i + 1];
        line_n--;
        line_buf[line_n] = '0;
        cursor_at--;
        stream_line(ACT_REDRAW, cursor_at, line_n);
      end
    end else if (c >= PRINT_LO && c <= PRINT_HI) begin
      if (line_n >= LINE_CAP - 1) begin
        push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
      end else begin
        for (int i = line_n; i > cursor_at; i--) line_buf[i] = line_buf[i - 1];
        line_buf[cursor_at] = c;
        cursor_at++;
        line_n++;
        stream_line(ACT_REDRAW, cursor_at, line_n);
      end
    end else begin
      push_result(ACT_NONE, 0, 0, cursor_at, line_n, 1'b1);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_key(key_code);
      if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        key_code <= pending_keys.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    editor_result_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {action, char_out, char_index, cursor_pos, line_length, last};
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected transfer %h", got));
        end else begin
          want = expected_results.pop_front();
          if (got.act != want.act) report($sformatf("action %0d want %0d", got.act, want.act));
          if (got.ch != want.ch) report($sformatf("char_out %0d want %0d", got.ch, want.ch));
          if (got.idx != want.idx) report($sformatf("char_index %0d want %0d", got.idx, want.idx));
          if (got.cur != want.cur) report($sformatf("cursor_pos %0d want %0d", got.cur, want.cur));
          if (got.len != want.len)
            report($sformatf("line_length %0d want %0d", got.len, want.len));
          if (got.fin != want.fin) report($sformatf("last %0d want %0d", got.fin, want.fin));
        end
      end
      if (hold_off && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
      out_stall <= (hold_off && hold_count < HOLD_CYCLES) || ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("console_line_editor_with_history: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (pending_keys.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    while (in_stall) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] r, input logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_KEY_UP: up_key = v;
      REG_KEY_DOWN: down_key = v;
      REG_KEY_LEFT: left_key = v;
      default: right_key = v;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] random_key();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 8'($urandom_range(PRINT_HI, PRINT_LO));
    if (p < 63) return KEY_BACKSPACE;
    if (p < 70) return KEY_ENTER;
    if (p < 77) return up_key;
    if (p < 83) return down_key;
    if (p < 89) return left_key;
    if (p < 94) return right_key;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_burst(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    repeat (n) pending_keys.push_back(random_key());
    drain();
  endtask

  initial begin
    up_key = KEY_UP_RESET; down_key = KEY_DOWN_RESET;
    left_key = KEY_LEFT_RESET; right_key = KEY_RIGHT_RESET;
    clear_line();
    hist_used = 0; hist_head = 0; browse_at = 0; browsing_on = 1'b0;
    for (int i = 0; i < HIST_DEPTH; i++) hist_len[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: dead keys on empty state, edits, commit, browse
    foreach (pending_keys[i]) ;
    pending_keys = '{8'd0, 8'd255, KEY_BACKSPACE, KEY_UP_RESET, KEY_DOWN_RESET,
                     KEY_LEFT_RESET, KEY_RIGHT_RESET, KEY_ENTER, PRINT_LO, PRINT_HI,
                     8'd31, 8'd127, KEY_LEFT_RESET, 8'h41, KEY_RIGHT_RESET,
                     KEY_RIGHT_RESET, KEY_LEFT_RESET, KEY_BACKSPACE, KEY_ENTER,
                     KEY_UP_RESET, KEY_UP_RESET, KEY_DOWN_RESET, KEY_DOWN_RESET,
                     KEY_DOWN_RESET, KEY_ENTER};
    drain();

    // fill line to capacity then overflow, commit; repeat commit for duplicate
    repeat (65) pending_keys.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
    pending_keys.push_back(KEY_UP_RESET);
    pending_keys.push_back(KEY_ENTER);
    pending_keys.push_back(KEY_UP_RESET);
    pending_keys.push_back(KEY_ENTER);
    drain();

    // long receiver hold-off while keys keep coming
    hold_off = 1'b1;
    repeat (12) pending_keys.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
    wait (hold_count == HOLD_CYCLES);
    hold_off = 1'b0;
    drain();

    random_burst(50, 0, 0);
    random_burst(40, 84, 0);
    random_burst(40, 0, 84);
    random_burst(30, 20, 20);

    // remapped cursor keys, including the extremes and keys that shadow enter and backspace
    write_key_reg(REG_KEY_UP, 8'd0);
    write_key_reg(REG_KEY_DOWN, 8'd255);
    write_key_reg(REG_KEY_LEFT, KEY_ENTER);
    write_key_reg(REG_KEY_RIGHT, 8'h61);
    random_burst(30, 20, 20);
    write_key_reg(REG_KEY_UP, 8'h7e);
    write_key_reg(REG_KEY_DOWN, KEY_BACKSPACE);
    write_key_reg(REG_KEY_LEFT, 8'd255);
    write_key_reg(REG_KEY_RIGHT, 8'd0);
    random_burst(30, 0, 0);

    if (errors == 0) begin
      $display("console_line_editor_with_history: match");
    end else begin
      $display("console_line_editor_with_history: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/cle_pkg.sv
sv/cle_datapath.sv
sv/cle_controller.sv
sv/console_line_editor_with_history.sv
sv/cle_checker.sv
dv/tb_console_line_editor_with_history.sv
